// File: design/bpm_pkg.sv
// Package with the shared types and constants of the button press and LED blink controller.
package bpm_pkg;

  // Event codes carried in the kind field of an input transfer.
  localparam logic [2:0] KIND_EDGE     = 3'd0;
  localparam logic [2:0] KIND_DEBOUNCE = 3'd1;
  localparam logic [2:0] KIND_BLINK    = 3'd2;
  localparam logic [2:0] KIND_SET_LED  = 3'd3;
  localparam logic [2:0] KIND_BLINK_CMD = 3'd4;

  // LED channel numbers.
  localparam int unsigned LED_BLUE  = 0;
  localparam int unsigned LED_GREEN = 1;

  // Configuration register map.
  localparam int unsigned CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] ADDR_LONG_PRESS = 2'd0;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd50;

  // Fixed values used by the long-press indication, the blink channels and the press counter.
  localparam logic [14:0] INDICATOR_RELOAD = 15'd499;
  localparam logic [7:0]  COUNT_FOREVER    = 8'hFF;
  localparam logic [15:0] PRESS_MAX        = 16'hFFFF;

  typedef struct packed {
    logic [2:0]        kind;
    logic              button_released;
    logic              led_index;
    logic              led_turn_on;
    logic [15:0]       blink_period_ms;
    logic signed [7:0] blinks_wanted;
  } in_data_t;

  typedef struct packed {
    logic        blue_lit;
    logic        green_lit;
    logic        measure_start;
    logic        mode_wireless;
    logic        blink_timer_on;
    logic [14:0] blink_reload;
    logic        debounce_timer_on;
  } out_data_t;

endpackage

// File: design/bpm_cfg.sv
// APB-style configuration register block holding the long-press threshold.
module bpm_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [bpm_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready,
  output logic [15:0]                       long_press_ticks
);

  logic [15:0] long_press_r;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r <= bpm_pkg::LONG_PRESS_RESET;
    end else if (wr_en && (cfg_paddr == bpm_pkg::ADDR_LONG_PRESS)) begin
      long_press_r <= cfg_pwdata[15:0];
    end
  end

  always_comb begin
    cfg_prdata = 32'd0;
    if (cfg_paddr == bpm_pkg::ADDR_LONG_PRESS) begin
      cfg_prdata = {16'd0, long_press_r};
    end
  end

  assign long_press_ticks = long_press_r;

endmodule

// File: design/bpm_core.sv
// Event processing core: press timing, transfer mode, blink channels and green priority.
module bpm_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  bpm_pkg::in_data_t   item,
  input  logic [15:0]         long_press_ticks,
  output bpm_pkg::out_data_t  result
);

  logic              deb_r,     deb_nxt;
  logic [15:0]       press_r,   press_nxt;
  logic              mode_r,    mode_nxt;
  logic [1:0]        req_r,     req_nxt;
  logic [1:0]        phase_r,   phase_nxt;
  logic [1:0]        en_r,      en_nxt;
  logic [1:0][7:0]   left_r,    left_nxt;
  logic              green_r,   green_nxt;
  logic              run_r,     run_nxt;
  logic [14:0]       reload_r,  reload_nxt;
  logic              pulse;
  logic [15:0]       press_inc;

  always_comb begin
    deb_nxt    = deb_r;
    press_nxt  = press_r;
    mode_nxt   = mode_r;
    req_nxt    = req_r;
    phase_nxt  = phase_r;
    en_nxt     = en_r;
    left_nxt   = left_r;
    green_nxt  = green_r;
    run_nxt    = run_r;
    reload_nxt = reload_r;
    pulse      = 1'b0;
    press_inc  = press_r;

    case (item.kind)
      bpm_pkg::KIND_EDGE: begin
        deb_nxt = 1'b1;
      end
      bpm_pkg::KIND_DEBOUNCE: begin
        if (deb_r) begin
          if (!item.button_released && (press_r != bpm_pkg::PRESS_MAX)) begin
            press_inc = press_r + 16'd1;
          end
          press_nxt = press_inc;
          if (item.button_released || (press_inc > long_press_ticks)) begin
            pulse = (press_inc != 16'd0) && (press_inc <= long_press_ticks);
            if (press_inc > long_press_ticks) begin
              mode_nxt = ~mode_r;
              req_nxt[bpm_pkg::LED_GREEN] = 1'b0;
              reload_nxt = bpm_pkg::INDICATOR_RELOAD;
              run_nxt = 1'b1;
              en_nxt[bpm_pkg::LED_BLUE] = 1'b1;
              left_nxt[bpm_pkg::LED_BLUE] = (~mode_r) ? 8'd2 : 8'd1;
            end
            press_nxt = 16'd0;
            deb_nxt = 1'b0;
          end
        end
      end
      bpm_pkg::KIND_BLINK: begin
        for (int ch = 0; ch < 2; ch++) begin
          if ((left_nxt[ch] != 8'd0) && en_nxt[ch]) begin
            if (!phase_nxt[ch]) begin
              req_nxt[ch]   = 1'b1;
              phase_nxt[ch] = 1'b1;
            end else begin
              req_nxt[ch]   = 1'b0;
              phase_nxt[ch] = 1'b0;
              if (left_nxt[ch] != bpm_pkg::COUNT_FOREVER) begin
                left_nxt[ch] = left_nxt[ch] - 8'd1;
                if (left_nxt[ch] == 8'd0) begin
                  en_nxt[ch] = 1'b0;
                  if (en_nxt == 2'b00) begin
                    run_nxt = 1'b0;
                  end
                end
              end
            end
          end
        end
      end
      bpm_pkg::KIND_SET_LED: begin
        req_nxt[item.led_index] = item.led_turn_on;
      end
      bpm_pkg::KIND_BLINK_CMD: begin
        if (item.led_turn_on) begin
          reload_nxt = (item.blink_period_ms >= 16'd2) ?
                       (item.blink_period_ms[15:1] - 15'd1) : 15'd0;
          run_nxt = 1'b1;
          en_nxt[item.led_index] = 1'b1;
          left_nxt[item.led_index] = $unsigned(item.blinks_wanted);
        end else begin
          en_nxt[item.led_index] = 1'b0;
          left_nxt[item.led_index] = 8'd0;
          if (en_nxt == 2'b00) begin
            run_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    // Green may come on only while blue is neither requested nor blinking.
    if (req_nxt[bpm_pkg::LED_GREEN] && !req_nxt[bpm_pkg::LED_BLUE] &&
        !en_nxt[bpm_pkg::LED_BLUE]) begin
      green_nxt = 1'b1;
    end
    if (!req_nxt[bpm_pkg::LED_GREEN]) begin
      green_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r    <= 1'b0;
      press_r  <= 16'd0;
      mode_r   <= 1'b0;
      req_r    <= 2'b00;
      phase_r  <= 2'b00;
      en_r     <= 2'b00;
      left_r   <= '0;
      green_r  <= 1'b0;
      run_r    <= 1'b0;
      reload_r <= 15'd0;
    end else if (step_en) begin
      deb_r    <= deb_nxt;
      press_r  <= press_nxt;
      mode_r   <= mode_nxt;
      req_r    <= req_nxt;
      phase_r  <= phase_nxt;
      en_r     <= en_nxt;
      left_r   <= left_nxt;
      green_r  <= green_nxt;
      run_r    <= run_nxt;
      reload_r <= reload_nxt;
    end
  end

  always_comb begin
    result.blue_lit          = req_nxt[bpm_pkg::LED_BLUE];
    result.green_lit         = green_nxt;
    result.measure_start     = pulse;
    result.mode_wireless     = mode_nxt;
    result.blink_timer_on    = run_nxt;
    result.blink_reload      = reload_nxt;
    result.debounce_timer_on = deb_nxt;
  end

endmodule

// File: design/button_press_mode_and_led_blinker.sv
// Top level of the button press mode and LED blink controller.
//
//  Channel  | Ports                                  | Direction | Moves
//  ---------+----------------------------------------+-----------+---------------------------
//  input    | in_valid, in_stall, in_data            | in        | one event per transfer
//  result   | out_valid, out_stall, out_data         | out       | one result per event
//  config   | cfg_psel/penable/pwrite/paddr/pwdata.. | in        | long_press_ticks write
//
// Every accepted input transfer yields exactly one result transfer: the event waits in
// the input register, then passes through the core into the result register. One event
// is accepted per cycle while the result side does not stall; the rate is set by the
// single pass through the core's state update. rst_n is synchronous and active low; it
// clears the pipeline valids, all event state and sets the threshold to 50. A stall on
// the result side holds the result register and any waiting event, raising in_stall.
module button_press_mode_and_led_blinker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  bpm_pkg::in_data_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output bpm_pkg::out_data_t              out_data,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [bpm_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);

  logic                s1_valid_r;
  bpm_pkg::in_data_t   s1_data_r;
  logic                out_valid_r;
  bpm_pkg::out_data_t  out_data_r;
  logic                in_take;
  logic                s1_adv;
  logic [15:0]         long_press_ticks;
  bpm_pkg::out_data_t  core_result;

  // The register block holds the threshold; the user must write it only while the block is idle (not enforced here).
  bpm_cfg u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready),
    .long_press_ticks (long_press_ticks)
  );

  // The event in the input register moves into the result register whenever that
  // register is empty or is handing off its result in this cycle.
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
  end

  // The core commits its state change in the same cycle the result is captured.
  bpm_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .step_en          (s1_adv),
    .item             (s1_data_r),
    .long_press_ticks (long_press_ticks),
    .result           (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= core_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A short-press pulse always ends the debounce window.
  a_pulse_ends_debounce: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.measure_start) |-> !out_data_r.debounce_timer_on)
    else $error("measure_start seen while debouncing is still active");

  // The input side only stalls while an event is held in the input register.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("in_stall raised with an empty input register");

  // An event that could not advance stays in the input register unchanged.
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_data_r)))
    else $error("held event in the input register was lost or changed");

endmodule
